// File: rtl/sm64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm64_pkg: shared types and constants for the SplitMix64 generator
// Mixing constants, request classes, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package sm64_pkg;

   // Golden-ratio increment and the two mixing multipliers
   localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

   // Fraction mode drops the low 12 bits of the word
   localparam int unsigned FRAC_SHIFT = 12;

   // Request opcodes; opcode 3 behaves as raw
   localparam logic [1:0] OPC_RAW   = 2'd0;
   localparam logic [1:0] OPC_FRAC  = 2'd1;
   localparam logic [1:0] OPC_BOUND = 2'd2;

   // Job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // 64-bit product built from three 32x32 partial products
   localparam logic [1:0] MUL_PH_LO    = 2'd0;
   localparam logic [1:0] MUL_PH_CROSS = 2'd1;
   localparam logic [1:0] MUL_PH_LAST  = 2'd2;

   // Remainder takes one radix-2 step per cycle
   localparam int unsigned DIV_STEPS = 64;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // What the back end has to do with a request
   typedef enum logic [1:0] {
      KIND_RAW,
      KIND_FRAC,
      KIND_BOUND,
      KIND_ZERO
   } sm64_kind_type;

   typedef struct packed {
      sm64_kind_type kind;
      logic [63:0]   low_bound;
      logic [63:0]   range;
   } sm64_job_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic         valid;
      sm64_job_type job;
   } sm64_qhead_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAW,
      ST_MULA,
      ST_XS27,
      ST_MULB,
      ST_XS31,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } sm64_state_type;

endpackage

// File: rtl/sm64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm64_front: request intake and classification
// Works out the bounded range and sorts each request into a job class.
// ----------------------------------------------------------------------------
module sm64_front (
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [63:0]           req_low_bound,
   input  logic [63:0]           req_high_bound,
   input  logic                  q_full,
   output logic                  push,
   output sm64_pkg::sm64_job_type push_job
);

   logic [63:0] range;

   // Range wraps mod 2^64; a zero range is answered without a draw
   always_comb begin
      range              = req_high_bound - req_low_bound;
      push_job.low_bound = req_low_bound;
      push_job.range     = range;
      case (req_opcode)
         sm64_pkg::OPC_FRAC: begin
            push_job.kind = sm64_pkg::KIND_FRAC;
         end
         sm64_pkg::OPC_BOUND: begin
            push_job.kind = (range == 64'd0) ? sm64_pkg::KIND_ZERO
                                             : sm64_pkg::KIND_BOUND;
         end
         default: begin
            push_job.kind = sm64_pkg::KIND_RAW;
         end
      endcase
   end

   // Take a transfer whenever the queue has room and reset is low
   assign req_ready = !q_full && !reset;
   assign push      = req_valid && req_ready;

endmodule

// File: rtl/sm64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm64_queue: job queue between front and back
// Small circular FIFO so that intake and generation stall independently.
// ----------------------------------------------------------------------------
module sm64_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sm64_pkg::sm64_job_type  push_job,
   output logic                    full,
   input  logic                    pop,
   output sm64_pkg::sm64_qhead_type head
);

   sm64_pkg::sm64_job_type              entries_ff [sm64_pkg::QUEUE_DEPTH];
   logic [sm64_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sm64_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sm64_pkg::QCNT_W-1:0]         count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sm64_pkg::QPTR_W'(sm64_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sm64_pkg::QPTR_W'(sm64_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full       = (count_ff == sm64_pkg::QCNT_W'(sm64_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];

endmodule

// File: rtl/sm64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm64_back: word generation, reduction and result register
// Sequencer around one 32x32 multiplier and a radix-2 remainder unit.
// ----------------------------------------------------------------------------
module sm64_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [63:0]              csr_data,
   input  sm64_pkg::sm64_qhead_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_value,
   output logic                     rsp_range_error
);

   sm64_pkg::sm64_state_type        state_ff, state_in;
   sm64_pkg::sm64_job_type          job_ff, job_in;
   logic [63:0]                     cnt_ff, cnt_in;
   logic [63:0]                     z_ff, z_in;
   logic [63:0]                     acc_ff, acc_in;
   logic [1:0]                      mul_ph_ff, mul_ph_in;
   logic [63:0]                     dvd_ff, dvd_in;
   logic [63:0]                     rem_ff, rem_in;
   logic [sm64_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [63:0]                     res_value_ff, res_value_in;
   logic                            res_err_ff, res_err_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [63:0]                     rsp_value_ff, rsp_value_in;
   logic                            rsp_err_ff, rsp_err_in;

   logic [63:0] sum;
   logic [63:0] mul_k;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] word;
   logic [64:0] rem_sh;
   logic [64:0] rem_diff;
   logic        reject;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      mul_ph_in    = mul_ph_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      res_value_in = res_value_ff;
      res_err_in   = res_err_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;

      // Counter advance; the first xor-shift follows in the draw state
      sum = cnt_ff + sm64_pkg::GOLDEN_INC;

      // Shared multiplier: low, cross and high-by-low partial products
      mul_k = (state_ff == sm64_pkg::ST_MULA) ? sm64_pkg::MIX_MUL_A
                                              : sm64_pkg::MIX_MUL_B;
      case (mul_ph_ff)
         sm64_pkg::MUL_PH_LO: begin
            mul_a = z_ff[31:0];
            mul_b = mul_k[31:0];
         end
         sm64_pkg::MUL_PH_CROSS: begin
            mul_a = z_ff[31:0];
            mul_b = mul_k[63:32];
         end
         default: begin
            mul_a = z_ff[63:32];
            mul_b = mul_k[31:0];
         end
      endcase
      prod = mul_a * mul_b;

      // Final xor-shift gives the word
      word = z_ff ^ (z_ff >> 31);

      // One restoring remainder step
      rem_sh   = {rem_ff, dvd_ff[63]};
      rem_diff = rem_sh - {1'b0, job_ff.range};

      // Redraw while the block of range values starting at w - r passes 2^64
      reject = (z_ff - rem_ff) > (64'd0 - job_ff.range);

      case (state_ff)
         sm64_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               job_in = head.job;
               if (head.job.kind == sm64_pkg::KIND_ZERO) begin
                  res_value_in = head.job.low_bound;
                  res_err_in   = 1'b1;
                  state_in     = sm64_pkg::ST_DONE;
               end else begin
                  state_in = sm64_pkg::ST_DRAW;
               end
            end
         end
         sm64_pkg::ST_DRAW: begin
            cnt_in    = sum;
            z_in      = sum ^ (sum >> 30);
            mul_ph_in = sm64_pkg::MUL_PH_LO;
            state_in  = sm64_pkg::ST_MULA;
         end
         sm64_pkg::ST_MULA, sm64_pkg::ST_MULB: begin
            if (mul_ph_ff == sm64_pkg::MUL_PH_LO) begin
               acc_in    = prod;
               mul_ph_in = sm64_pkg::MUL_PH_CROSS;
            end else begin
               acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
               if (mul_ph_ff == sm64_pkg::MUL_PH_LAST) begin
                  z_in     = acc_in;
                  state_in = (state_ff == sm64_pkg::ST_MULA) ? sm64_pkg::ST_XS27
                                                             : sm64_pkg::ST_XS31;
               end else begin
                  mul_ph_in = sm64_pkg::MUL_PH_LAST;
               end
            end
         end
         sm64_pkg::ST_XS27: begin
            z_in      = z_ff ^ (z_ff >> 27);
            mul_ph_in = sm64_pkg::MUL_PH_LO;
            state_in  = sm64_pkg::ST_MULB;
         end
         sm64_pkg::ST_XS31: begin
            z_in       = word;
            res_err_in = 1'b0;
            case (job_ff.kind)
               sm64_pkg::KIND_BOUND: begin
                  dvd_in     = word;
                  rem_in     = '0;
                  div_cnt_in = sm64_pkg::DIV_CNT_W'(sm64_pkg::DIV_STEPS - 1);
                  state_in   = sm64_pkg::ST_DIV;
               end
               sm64_pkg::KIND_FRAC: begin
                  res_value_in = word >> sm64_pkg::FRAC_SHIFT;
                  state_in     = sm64_pkg::ST_DONE;
               end
               default: begin
                  res_value_in = word;
                  state_in     = sm64_pkg::ST_DONE;
               end
            endcase
         end
         sm64_pkg::ST_DIV: begin
            rem_in     = rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
            dvd_in     = {dvd_ff[62:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = sm64_pkg::ST_CHECK;
            end
         end
         sm64_pkg::ST_CHECK: begin
            if (reject) begin
               state_in = sm64_pkg::ST_DRAW;
            end else begin
               res_value_in = rem_ff + job_ff.low_bound;
               res_err_in   = 1'b0;
               state_in     = sm64_pkg::ST_DONE;
            end
         end
         sm64_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_err_in   = res_err_ff;
               state_in     = sm64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sm64_pkg::ST_IDLE;
         end
      endcase

      // Seed write reloads the counter
      if (csr_write) begin
         cnt_in = csr_data;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sm64_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      z_ff         <= z_in;
      acc_ff       <= acc_in;
      mul_ph_ff    <= mul_ph_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      res_value_ff <= res_value_in;
      res_err_ff   <= res_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

// File: rtl/splitmix64_bounded_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix64_bounded_generator_top: SplitMix64 generator with bounded mode
// Raw word, 52-bit fraction or integer in [low, high) per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer carries
// req_      in         opcode, low_bound, high_bound
// rsp_      out        value, range_error
// csr_      in         seed (also reloads the counter)
//
// Raw and fraction requests pass through the back end as a counter add,
// two multiplies of three partial products each on one 32x32 multiplier
// and three xor-shifts. Bounded requests add 64 remainder steps and a
// check; a rejected word is drawn again. A zero range skips the draw.
// A two-entry queue lets requests be taken while the back end is busy;
// the result register holds a stalled response while the next is generated.
// Reset is synchronous and clears the counter to zero.
// ----------------------------------------------------------------------------
module splitmix64_bounded_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_low_bound,
   input  logic [63:0] req_high_bound,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_range_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   logic                      q_full;
   logic                      push;
   sm64_pkg::sm64_job_type    push_job;
   logic                      pop;
   sm64_pkg::sm64_qhead_type  head;
   logic                      csr_write;

   // Seed writes are always taken outside reset
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   sm64_front u_front (
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .q_full         (q_full),
      .push           (push),
      .push_job       (push_job)
   );

   sm64_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   sm64_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_data        (csr_data),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule

// File: rtl/sm64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm64_checker: port-level checks for the SplitMix64 generator
// Tracks outstanding requests and checks response ordering and holding.
// ----------------------------------------------------------------------------
module sm64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic        rsp_range_error
);

   logic [2:0] pend_ff, pend_in;

   // Requests taken but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Nothing is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // No response without a request in flight
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 3'd0))
      else $error("response without an outstanding request");

   // Queue, back end and result register hold at most four requests
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 3'd4) |-> !req_ready)
      else $error("more requests accepted than the block can hold");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value) && $stable(rsp_range_error)))
      else $error("stalled response changed");

endmodule

bind splitmix64_bounded_generator_top sm64_checker u_sm64_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_value       (rsp_value),
   .rsp_range_error (rsp_range_error)
);
